@@ design/dcfir_pkg.sv @@
package dcfir_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int COEF_FRAC_BITS = 15;
    localparam int TABLE_LEN      = 51;
    localparam int TAPS_DEFAULT   = 51;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] red_sample;
        logic signed [SAMPLE_BITS-1:0] ir_sample;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] red_filtered;
        logic signed [SAMPLE_BITS-1:0] ir_filtered;
    } t_out;

    // per-cycle control from the sequencer to every lane
    typedef struct packed {
        logic shift;  // new sample enters the window
        logic mac;    // multiply the front tap and rotate
        logic first;  // first tap of the sum
    } t_lane_ctl;

    typedef logic signed [COEF_BITS-1:0] t_coef;
    typedef t_coef t_coef_tab [TABLE_LEN];

    // q1.15 symmetric low-pass taps
    localparam t_coef_tab COEF_TAB = '{
        16'sd0,    16'sd5,    16'sd13,   16'sd23,   16'sd39,
        16'sd61,   16'sd91,   16'sd131,  16'sd180,  16'sd240,
        16'sd312,  16'sd393,  16'sd485,  16'sd585,  16'sd691,
        16'sd801,  16'sd914,  16'sd1025, 16'sd1133, 16'sd1234,
        16'sd1325, 16'sd1403, 16'sd1467, 16'sd1514, 16'sd1543,
        16'sd1552, 16'sd1543, 16'sd1514, 16'sd1467, 16'sd1403,
        16'sd1325, 16'sd1234, 16'sd1133, 16'sd1025, 16'sd914,
        16'sd801,  16'sd691,  16'sd585,  16'sd485,  16'sd393,
        16'sd312,  16'sd240,  16'sd180,  16'sd131,  16'sd91,
        16'sd61,   16'sd39,   16'sd23,   16'sd13,   16'sd5,
        16'sd0
    };

    // taps past the end of the table are zero
    function automatic t_coef coef_at(input int unsigned k);
        t_coef c;
        c = '0;
        if (k < TABLE_LEN) begin
            c = COEF_TAB[k];
        end
        return c;
    endfunction

endpackage

@@ design/dcfir_seq.sv @@
module dcfir_seq #(
    parameter int TAP_COUNT = dcfir_pkg::TAPS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_out_free,
    output dcfir_pkg::t_lane_ctl  o_ctl,
    output dcfir_pkg::t_coef      o_coef,
    output logic                  o_load
);
    import dcfir_pkg::*;

    localparam int KW = $clog2(TAP_COUNT);
    localparam logic [KW-1:0] K_LAST = KW'(TAP_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_ACC,
        S_FIN
    } t_state;

    t_state          r_state;
    logic [KW-1:0]   r_k;

    assign o_stall     = (r_state != S_IDLE);
    assign o_ctl.shift = i_valid && (r_state == S_IDLE);
    assign o_ctl.mac   = (r_state == S_RUN);
    assign o_ctl.first = (r_k == '0);
    assign o_coef      = coef_at(int'(r_k));
    assign o_load      = (r_state == S_FIN) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (i_valid) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_k == K_LAST) begin
                        r_k     <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_ACC: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/dcfir_lane.sv @@
module dcfir_lane #(
    parameter int TAP_COUNT = dcfir_pkg::TAPS_DEFAULT,
    parameter int ACC_W     = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  dcfir_pkg::t_lane_ctl                   i_ctl,
    input  dcfir_pkg::t_coef                       i_coef,
    input  logic signed [dcfir_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic signed [ACC_W-1:0]                o_acc
);
    import dcfir_pkg::*;

    localparam int PW = SAMPLE_BITS + COEF_BITS;

    // window: newest sample at index 0, rotated during the sum
    logic signed [SAMPLE_BITS-1:0] r_win [TAP_COUNT];
    logic signed [PW-1:0]          r_prod;
    logic                          r_pv;
    logic                          r_pfirst;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_win[0] <= i_sample;
            for (int i = 1; i < TAP_COUNT; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end else if (i_ctl.mac) begin
            for (int i = 0; i < TAP_COUNT - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[TAP_COUNT-1] <= r_win[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pv     <= i_ctl.mac;
            r_pfirst <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_win[0] * i_coef;
    end

    always_comb begin
        n_acc = r_acc;
        if (r_pv) begin
            n_acc = (r_pfirst ? ACC_W'(0) : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

@@ design/dcfir_merge.sv @@
module dcfir_merge #(
    parameter int ACC_W = 40
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [ACC_W-1:0] i_acc_red,
    input  logic signed [ACC_W-1:0] i_acc_ir,
    input  logic                    i_stall,
    output logic                    o_valid,
    output dcfir_pkg::t_out         o_data
);
    import dcfir_pkg::*;

    localparam int RW = ACC_W + 1;
    localparam logic signed [RW-1:0] HALF  = RW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [RW-1:0] S_MAX = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] S_MIN = -S_MAX - RW'(1);

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [RW-1:0] s;
        logic signed [SAMPLE_BITS-1:0] y;
        s = (RW'(a) + HALF) >>> COEF_FRAC_BITS;
        if (s > S_MAX) begin
            y = S_MAX[SAMPLE_BITS-1:0];
        end else if (s < S_MIN) begin
            y = S_MIN[SAMPLE_BITS-1:0];
        end else begin
            y = s[SAMPLE_BITS-1:0];
        end
        return y;
    endfunction

    logic r_valid;
    t_out r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.red_filtered <= round_sat(i_acc_red);
            r_data.ir_filtered  <= round_sat(i_acc_ir);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/dual_channel_fir_lowpass_top.sv @@
// flow: an accepted request walks the taps, then the accumulate and finish states;
//   finish loads the output register once it is free; no new request is taken until
//   then, as a single multiply-accumulate per lane walks the taps one per cycle
// reset: synchronous, active low; clears both sample windows to zero and
//   empties the output register
module dual_channel_fir_lowpass_top #(
    parameter int TAP_COUNT = dcfir_pkg::TAPS_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_valid,
    output logic            o_stall,
    input  dcfir_pkg::t_in  i_data,
    // output channel
    output logic            o_valid,
    input  logic            i_stall,
    output dcfir_pkg::t_out o_data
);
    import dcfir_pkg::*;

    // full-width sum: product bits plus growth over all taps
    localparam int ACC_W = SAMPLE_BITS + COEF_BITS + $clog2(TAP_COUNT);

    t_lane_ctl               lane_ctl;
    t_coef                   coef;
    logic                    load;
    logic                    out_free;
    logic signed [ACC_W-1:0] acc_red;
    logic signed [ACC_W-1:0] acc_ir;

    // output register can take a new result when empty or being drained
    assign out_free = !o_valid || !i_stall;

    // tap counter and control; one coefficient read shared by both lanes
    dcfir_seq #(
        .TAP_COUNT (TAP_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_out_free (out_free),
        .o_ctl      (lane_ctl),
        .o_coef     (coef),
        .o_load     (load)
    );

    // red lane: rotating window, registered product, accumulator
    dcfir_lane #(
        .TAP_COUNT (TAP_COUNT),
        .ACC_W     (ACC_W)
    ) u_lane_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_coef   (coef),
        .i_sample (i_data.red_sample),
        .o_acc    (acc_red)
    );

    // infrared lane, same structure
    dcfir_lane #(
        .TAP_COUNT (TAP_COUNT),
        .ACC_W     (ACC_W)
    ) u_lane_ir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_coef   (coef),
        .i_sample (i_data.ir_sample),
        .o_acc    (acc_ir)
    );

    // round half up, saturate, and hold the result pair until taken
    dcfir_merge #(
        .ACC_W (ACC_W)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_acc_red (acc_red),
        .i_acc_ir  (acc_ir),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_data    (o_data)
    );

endmodule
